// ===== sv/wmvoc_pkg.sv =====
// Shared types and constants for the windowed median VOC event detector.
// No dependencies.
package wmvoc_pkg;

  localparam int DATA_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_WINDOWS = 4;
  localparam int DEF_WINDOW_LEN = 6;
  localparam int DEF_RING_DEPTH = 24;

  localparam logic [DATA_W-1:0] ONSET_RESET    = 16'd300;
  localparam logic [DATA_W-1:0] RECOVERY_RESET = 16'd300;
  localparam logic [DATA_W-1:0] REVERSAL_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_ONSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSAL = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_UNDECIDED = 2'd0,
    VERDICT_NORMAL    = 2'd1,
    VERDICT_ONSET     = 2'd2,
    VERDICT_ACTIVE    = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_FETCH,
    ST_DRAIN,
    ST_MEDIAN,
    ST_JUDGE
  } state_t;

  typedef struct packed {
    logic load;
    logic store;
    logic fetch;
    logic take_median;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_fetch;
    logic last_window;
    logic result_free;
  } status_t;

endpackage

// ===== sv/wmvoc_if.sv =====
// Valid/ready channel interfaces for samples and verdicts.
// Depends on wmvoc_pkg.
interface wmvoc_sample_if;
  logic                      valid;
  logic                      ready;
  logic [wmvoc_pkg::DATA_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wmvoc_verdict_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                verdict;
  logic [wmvoc_pkg::DATA_W-1:0] baseline_level;
  modport source (output valid, output verdict, output baseline_level, input ready);
  modport sink   (input valid, input verdict, input baseline_level, output ready);
endinterface

// ===== sv/wmvoc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module wmvoc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/wmvoc_ctrl.sv =====
// Sequencer: store, fetch four windows, take medians, judge, hand off.
// Depends on wmvoc_pkg.
module wmvoc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wmvoc_pkg::status_t status,
  output wmvoc_pkg::cmd_t    cmd
);
  import wmvoc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        if (status.last_fetch) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_MEDIAN;
      end
      ST_MEDIAN: begin
        cmd.take_median = 1'b1;
        state_next = status.last_window ? ST_JUDGE : ST_FETCH;
      end
      ST_JUDGE: begin
        if (status.result_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== sv/wmvoc_datapath.sv =====
// Ring store, insertion sorter, window medians, event judgment and result register.
// Depends on wmvoc_pkg and wmvoc_ram.
module wmvoc_datapath #(
  parameter int WINDOW_LEN = wmvoc_pkg::DEF_WINDOW_LEN,
  parameter int RING_DEPTH = wmvoc_pkg::DEF_RING_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wmvoc_pkg::cmd_t                  cmd,
  output wmvoc_pkg::status_t               status,
  input  logic                             cfg_we,
  input  logic [wmvoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmvoc_pkg::DATA_W-1:0]     cfg_data,
  input  logic [wmvoc_pkg::DATA_W-1:0]     sample,
  input  logic                             result_ready,
  output logic                             result_valid,
  output logic [1:0]                       verdict,
  output logic [wmvoc_pkg::DATA_W-1:0]     baseline_level
);
  import wmvoc_pkg::*;

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int CW  = $clog2(WINDOW_LEN);
  localparam int MID = (WINDOW_LEN - 1) / 2;

  logic [DATA_W-1:0] onset_delta, recovery_delta, reversal_delta;
  logic [DATA_W-1:0] sample_reg;
  logic [AW-1:0]     wp, rd_addr;
  logic [RING_DEPTH-1:0] vld;
  logic [CW-1:0]     rcnt;
  logic [1:0]        widx;
  logic              data_vld, rd_vld;
  logic [DATA_W-1:0] ram_rdata, fetched;
  logic [DATA_W-1:0] lane      [WINDOW_LEN];
  logic [DATA_W-1:0] lane_next [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] lane_vld, lane_vld_next;
  logic [DATA_W-1:0] med [NUM_WINDOWS];
  logic [DATA_W-1:0] baseline, baseline_next;
  logic [DATA_W:0]   mid_sum;
  verdict_t          verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      onset_delta    <= ONSET_RESET;
      recovery_delta <= RECOVERY_RESET;
      reversal_delta <= REVERSAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONSET:    onset_delta    <= cfg_data;
        CFG_RECOVERY: recovery_delta <= cfg_data;
        CFG_REVERSAL: reversal_delta <= cfg_data;
        default: ;
      endcase
    end
  end

  wmvoc_ram #(.WIDTH(DATA_W), .DEPTH(RING_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (wp),
    .wdata (sample_reg),
    .re    (cmd.fetch),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign fetched = rd_vld ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= sample;
    end
    if (cmd.fetch) begin
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rd_addr  <= '0;
      vld      <= '0;
      rcnt     <= '0;
      widx     <= '0;
      data_vld <= 1'b0;
    end else begin
      data_vld <= cmd.fetch;
      if (cmd.store) begin
        vld[wp] <= 1'b1;
        rd_addr <= wp;
        wp      <= (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
        rcnt    <= '0;
        widx    <= '0;
      end
      if (cmd.fetch) begin
        rd_addr <= (rd_addr == '0) ? AW'(RING_DEPTH - 1) : rd_addr - 1'b1;
        rcnt    <= rcnt + 1'b1;
      end
      if (cmd.take_median) begin
        rcnt <= '0;
        widx <= widx + 1'b1;
      end
    end
  end

  // insertion sort lanes: ascending, filled from lane 0
  always_comb begin
    logic keep, prev_keep;
    keep = lane_vld[0] && (lane[0] <= fetched);
    lane_next[0]     = keep ? lane[0] : fetched;
    lane_vld_next[0] = 1'b1;
    for (int i = 1; i < WINDOW_LEN; i++) begin
      keep      = lane_vld[i] && (lane[i] <= fetched);
      prev_keep = lane_vld[i-1] && (lane[i-1] <= fetched);
      if (keep) begin
        lane_next[i]     = lane[i];
        lane_vld_next[i] = 1'b1;
      end else if (prev_keep) begin
        lane_next[i]     = fetched;
        lane_vld_next[i] = 1'b1;
      end else begin
        lane_next[i]     = lane[i-1];
        lane_vld_next[i] = lane_vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.store || cmd.take_median) begin
      lane_vld <= '0;
    end else if (data_vld) begin
      lane_vld <= lane_vld_next;
    end
    if (data_vld) begin
      lane <= lane_next;
    end
  end

  assign mid_sum = {1'b0, lane[MID]} + {1'b0, lane[MID+1]};

  always_ff @(posedge clk) begin
    if (cmd.take_median) begin
      med[widx] <= mid_sum[DATA_W:1];
    end
  end

  always_comb begin
    logic            any_zero, onset, recover, reversal;
    logic [DATA_W:0] ad_sum;
    any_zero = (med[0] == '0) || (med[1] == '0) || (med[2] == '0) || (med[3] == '0);
    onset    = {1'b0, med[3]} >= ({1'b0, med[0]} + {1'b0, onset_delta});
    recover  = {1'b0, med[0]} >= ({1'b0, baseline} + {1'b0, recovery_delta});
    reversal = {1'b0, med[0]} >= ({1'b0, med[3]} + {1'b0, reversal_delta});
    ad_sum   = {1'b0, med[0]} + {1'b0, med[3]};
    baseline_next = baseline;
    if (any_zero) begin
      verdict_next = VERDICT_UNDECIDED;
    end else if (onset) begin
      if (baseline == '0) begin
        baseline_next = ad_sum[DATA_W:1];
        verdict_next  = VERDICT_ONSET;
      end else begin
        verdict_next = VERDICT_ACTIVE;
      end
    end else if (baseline == '0) begin
      verdict_next = VERDICT_NORMAL;
    end else if (recover || reversal) begin
      baseline_next = '0;
      verdict_next  = VERDICT_NORMAL;
    end else begin
      verdict_next = VERDICT_ACTIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline     <= '0;
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      baseline     <= baseline_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (cmd.commit) begin
      verdict        <= verdict_next;
      baseline_level <= baseline_next;
    end
  end

  assign status.last_fetch  = (rcnt == CW'(WINDOW_LEN - 1));
  assign status.last_window = (widx == 2'(NUM_WINDOWS - 1));
  assign status.result_free = !result_valid || result_ready;
endmodule

// ===== sv/windowed_median_voc_event_detector.sv =====
// A new sample is accepted only in the idle state, after the previous one has been judged and
// its result committed, which waits while an earlier result is still not taken. The single
// RAM read port delivers one stored sample per cycle to the insertion sorter while fetching a window.
// Reset (rst, synchronous): store reads as zero, pointer and baseline zero, registers
// return to 300/300/100, no result pending.
module windowed_median_voc_event_detector #(
  parameter int WINDOW_LEN = wmvoc_pkg::DEF_WINDOW_LEN,
  parameter int RING_DEPTH = wmvoc_pkg::DEF_RING_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  wmvoc_sample_if.sink                    feed,
  wmvoc_verdict_if.source                 report,
  input  logic                            cfg_we,
  input  logic [wmvoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmvoc_pkg::DATA_W-1:0]    cfg_data
);
  import wmvoc_pkg::*;

  cmd_t    cmd;
  status_t status;

  wmvoc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (feed.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wmvoc_datapath #(.WINDOW_LEN(WINDOW_LEN), .RING_DEPTH(RING_DEPTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (feed.sample),
    .result_ready   (report.ready),
    .result_valid   (report.valid),
    .verdict        (report.verdict),
    .baseline_level (report.baseline_level)
  );
endmodule

// ===== sv/wmvoc_checker.sv =====
// Port-level checks on the detector's result channel, bound to the top level.
// Depends on wmvoc_pkg.
module wmvoc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   verdict,
  input logic [wmvoc_pkg::DATA_W-1:0] baseline_level
);
  import wmvoc_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_normal_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == VERDICT_NORMAL) |-> baseline_level == '0)
    else $error("normal verdict with nonzero baseline");

  a_event_base: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (verdict == VERDICT_ONSET || verdict == VERDICT_ACTIVE))
      |-> baseline_level != '0)
    else $error("event verdict without baseline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(verdict) && $stable(baseline_level)))
    else $error("stalled result changed");
endmodule

bind windowed_median_voc_event_detector wmvoc_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (report.valid),
  .out_ready      (report.ready),
  .verdict        (report.verdict),
  .baseline_level (report.baseline_level)
);

// ===== tb/windowed_median_voc_event_detector_tb.sv =====
// Testbench for windowed_median_voc_event_detector: drives samples, configuration
// writes and random stalls, and checks each verdict against a scoreboard predictor.
// Depends on wmvoc_pkg, wmvoc_if and the detector RTL.
`timescale 1ns / 1ps

module windowed_median_voc_event_detector_tb;
  import wmvoc_pkg::*;

  localparam int WLEN  = DEF_WINDOW_LEN;
  localparam int DEPTH = DEF_RING_DEPTH;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  class verdict_scoreboard;
    logic [DATA_W-1:0] onset_thr, recovery_thr, reversal_thr;
    logic [DATA_W-1:0] ring [DEPTH];
    int unsigned       wr_slot;
    logic [DATA_W-1:0] base_level;
    verdict_t          pend_verdict [$];
    logic [DATA_W-1:0] pend_base [$];
    int                mismatches;
    int                checked;
    int                onsets;
    int                undecided;

    function void clear();
      onset_thr = ONSET_RESET;
      recovery_thr = RECOVERY_RESET;
      reversal_thr = REVERSAL_RESET;
      foreach (ring[i]) ring[i] = '0;
      wr_slot = 0;
      base_level = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      case (idx)
        CFG_ONSET:    onset_thr = val;
        CFG_RECOVERY: recovery_thr = val;
        CFG_REVERSAL: reversal_thr = val;
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] median_of(int unsigned win);
      logic [DATA_W-1:0] v [WLEN];
      logic [DATA_W-1:0] key;
      int unsigned span, back, j;
      int unsigned mid;
      span = WLEN * (win + 1);
      for (int i = 0; i < WLEN; i++) begin
        back = (span - i) % DEPTH;
        v[i] = ring[(wr_slot + DEPTH - back) % DEPTH];
      end
      for (int i = 1; i < WLEN; i++) begin
        key = v[i];
        j = i;
        while (j > 0 && v[j-1] > key) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = key;
      end
      mid = (WLEN - 1) / 2;
      return 16'((32'(v[mid]) + 32'(v[mid+1])) / 2);
    endfunction

    function verdict_t judge_windows();
      logic [DATA_W-1:0] med [4];
      int a, d;
      for (int k = 0; k < 4; k++) med[k] = median_of(k);
      for (int k = 0; k < 4; k++) if (med[k] == 0) return VERDICT_UNDECIDED;
      a = med[0];
      d = med[3];
      if (d - a >= int'(onset_thr)) begin
        if (base_level == 0) begin
          base_level = 16'((a + d) / 2);
          return VERDICT_ONSET;
        end
        return VERDICT_ACTIVE;
      end
      if (base_level == 0) return VERDICT_NORMAL;
      if (a - int'(base_level) >= int'(recovery_thr)) begin
        base_level = '0;
        return VERDICT_NORMAL;
      end
      if (a - d >= int'(reversal_thr)) begin
        base_level = '0;
        return VERDICT_NORMAL;
      end
      return VERDICT_ACTIVE;
    endfunction

    function void note_sample(logic [DATA_W-1:0] s);
      verdict_t v;
      ring[wr_slot] = s;
      wr_slot = (wr_slot + 1) % DEPTH;
      v = judge_windows();
      if (v == VERDICT_ONSET) onsets++;
      if (v == VERDICT_UNDECIDED) undecided++;
      pend_verdict.push_back(v);
      pend_base.push_back(base_level);
    endfunction

    function void check_result(logic [1:0] v, logic [DATA_W-1:0] b);
      verdict_t ev;
      logic [DATA_W-1:0] eb;
      checked++;
      if (pend_verdict.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result verdict=%0d base=%0d", v, b);
        return;
      end
      ev = pend_verdict.pop_front();
      eb = pend_base.pop_front();
      if (v !== ev || b !== eb) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: verdict exp %0d got %0d, base exp %0d got %0d",
                   checked, ev, v, eb, b);
      end
    endfunction

    function int pending();
      return pend_verdict.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  wmvoc_sample_if  feed ();
  wmvoc_verdict_if report ();

  verdict_scoreboard sb;
  int unsigned sent;

  windowed_median_voc_event_detector DUT (
    .clk(clk), .rst(rst), .feed(feed), .report(report),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst && report.valid && report.ready)
      sb.check_result(report.verdict, report.baseline_level);
  end

  initial begin
    int g;
    report.ready = 1'b0;
    @(posedge clk);
    forever begin
      g = gap_len();
      if (g == 0) begin
        report.ready <= 1'b1;
        @(posedge clk);
      end else begin
        report.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // Hold valid across back-to-back transactions; drop it only before a gap or a drain.
  task automatic push_sample(logic [DATA_W-1:0] s);
    int g;
    g = gap_len();
    if (g > 0) begin
      feed.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    feed.valid <= 1'b1;
    feed.sample <= s;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
    sb.note_sample(s);
    sent++;
  endtask

  task automatic drain();
    feed.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Level, then a dip, then a recovery: drives onset, continuing and end of event.
  task automatic event_sequence(int hi, int lo, int jitter);
    for (int i = 0; i < 4 * WLEN; i++)
      push_sample(16'(hi + $urandom_range(0, jitter)));
    for (int i = 0; i < 3 * WLEN; i++)
      push_sample(16'(lo + $urandom_range(0, jitter)));
    for (int i = 0; i < 2 * WLEN; i++)
      push_sample(16'(hi + $urandom_range(0, jitter)));
  endtask

  initial begin
    int hi, lo;
    sb = new();
    sb.clear();
    sent = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    feed.valid = 1'b0;
    feed.sample = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero medians from the cleared store, extremes, unused index
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h0001);
    for (int i = 0; i < 14; i++) push_sample(16'hFFFF);
    for (int i = 0; i < 7; i++) push_sample(16'h0001);
    drain();
    write_reg(CFG_UNUSED, 16'h1234);
    write_reg(CFG_ONSET, 16'hFFFF);
    write_reg(CFG_RECOVERY, 16'hFFFF);
    write_reg(CFG_REVERSAL, 16'hFFFF);
    end_writes();
    event_sequence(60000, 100, 3);
    drain();
    write_reg(CFG_ONSET, 16'h0000);
    write_reg(CFG_RECOVERY, 16'h0000);
    write_reg(CFG_REVERSAL, 16'h0000);
    end_writes();
    event_sequence(500, 400, 50);
    drain();

    // random: mostly dip-and-recover sequences, some noise
    while (sent < 650) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        write_reg(CFG_ONSET, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000)));
        write_reg(CFG_RECOVERY, 16'($urandom_range(0, 3) == 0 ? $urandom :
                                   $urandom_range(0, 2000)));
        write_reg(CFG_REVERSAL, 16'($urandom_range(0, 3) == 0 ? $urandom :
                                   $urandom_range(0, 2000)));
        end_writes();
      end
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 10; i++) push_sample(16'($urandom));
      end else begin
        hi = $urandom_range(1000, 65000);
        lo = $urandom_range(1, hi);
        event_sequence(hi, lo, $urandom_range(0, 400) > 300 ? 500 : 20);
      end
    end

    drain();
    $display("Sent %0d samples, checked %0d verdicts (%0d onsets, %0d undecided).",
             sent, sb.checked, sb.onsets, sb.undecided);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
